// ----- hw/rtl/rptm_pkg.sv -----
// Shared types and constants for the radix page table manager.
// No dependencies; used by every other file of the block but rptm_ram.
package rptm_pkg;

  localparam int POOL_TABLES_DEF = 64;
  localparam int FRAME_BITS_DEF  = 40;
  localparam int IDX_BITS        = 9;
  localparam int TABLE_ENTRIES   = 512;
  localparam int ENT_W           = 43;
  localparam int VA_W            = 48;
  localparam int SIZE_W          = 49;
  localparam int FRAME_W         = 40;
  localparam int CFG_W           = 49;

  // Operation codes
  localparam logic [1:0] OP_MAP     = 2'd0;
  localparam logic [1:0] OP_UNMAP   = 2'd1;
  localparam logic [1:0] OP_PROTECT = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_WINDOW_BASE = 1'b0;
  localparam logic CFG_WINDOW_SIZE = 1'b1;

  // Flags of a table link: present and writable
  localparam logic [2:0] LINK_FLAGS = 3'b011;

  // Commands to the table pool bitmap
  typedef struct packed {
    logic set;
    logic clr;
  } pool_cmd_t;

endpackage

// ----- hw/rtl/rptm_if.sv -----
// Request and response channel interfaces of the page table manager.
// Depends on rptm_pkg for field widths.
interface rptm_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic [rptm_pkg::VA_W-1:0]   virtual_address;
  logic [rptm_pkg::FRAME_W-1:0] physical_frame;
  logic                        writable;
  logic                        executable;
  logic                        frame_allocated;

  modport source (output valid, op, virtual_address, physical_frame, writable,
                  executable, frame_allocated, input ready);
  modport sink (input valid, op, virtual_address, physical_frame, writable,
                executable, frame_allocated, output ready);
endinterface

interface rptm_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [rptm_pkg::FRAME_W-1:0] result_frame;
  logic                         result_writable;
  logic                         result_executable;

  modport source (output valid, ok, result_frame, result_writable,
                  result_executable, input ready);
  modport sink (input valid, ok, result_frame, result_writable,
                result_executable, output ready);
endinterface

// ----- hw/rtl/radix_page_table_manager.sv -----
// Top level of the four-level radix page table manager.
// Depends on rptm_pkg, rptm_if, rptm_ram and rptm_pool.
//
// Usage:
//   Requests arrive on req (valid/ready); each carries an operation (map,
//   unmap, protect, query), a 4 KiB-aligned virtual address, a frame and
//   permission bits. Exactly one response per request leaves on rsp
//   (valid/ready) with ok and, for a query, the frame and permissions.
//   Window registers are written through cfg_write/cfg_index/cfg_data while
//   no request is in flight.
// Sequencing: one request at a time. A query or protect does one table read
//   per level. Map also allocates each missing table (pool scan plus a clear
//   of all 512 entries of the fresh table through the single RAM port).
//   Unmap also reads through each table it checks for emptiness. All entry
//   traffic goes through one RAM port.
// Reset: rst resets the sequencer, window and response-valid registers, then
//   zeroes all POOL_TABLES*512 entries, one per cycle, with req.ready low.
// Stall: the response waits in an output register; a new request is taken
//   while it waits, and the next response holds until rsp.ready.
module radix_page_table_manager #(
  parameter int POOL_TABLES = rptm_pkg::POOL_TABLES_DEF,
  parameter int FRAME_BITS  = rptm_pkg::FRAME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  rptm_req_if.sink                 req,
  rptm_rsp_if.source               rsp,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [rptm_pkg::CFG_W-1:0] cfg_data
);

  localparam int TBL_W = $clog2(POOL_TABLES);
  localparam int IW    = rptm_pkg::IDX_BITS;
  localparam int AW    = TBL_W + IW;
  localparam int FW    = rptm_pkg::FRAME_W;
  localparam int EW    = rptm_pkg::ENT_W;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(POOL_TABLES * rptm_pkg::TABLE_ENTRIES - 1);
  localparam logic [IW-1:0]    LAST_IDX  = IW'(rptm_pkg::TABLE_ENTRIES - 1);
  localparam logic [TBL_W-1:0] LAST_TBL  = TBL_W'(POOL_TABLES - 1);
  localparam logic [FW-1:0]    POOL_LIM  = FW'(POOL_TABLES);
  localparam logic [FW-1:0]    FMASK     = (FW'(1) << FRAME_BITS) - FW'(1);

  typedef enum logic [11:0] {
    S_CLR  = 12'b000000000001,
    S_IDLE = 12'b000000000010,
    S_CHK  = 12'b000000000100,
    S_RD   = 12'b000000001000,
    S_EV   = 12'b000000010000,
    S_AL   = 12'b000000100000,
    S_ZE   = 12'b000001000000,
    S_LK   = 12'b000010000000,
    S_RB   = 12'b000100000000,
    S_SC   = 12'b001000000000,
    S_FR   = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_t;

  state_t state;

  // Window registers
  logic [rptm_pkg::VA_W-1:0]   window_base;
  logic [rptm_pkg::SIZE_W-1:0] window_size;

  // Captured request
  logic [1:0]                op_r;
  logic [rptm_pkg::VA_W-1:0] va_r;
  logic [FW-1:0]             frame_r;
  logic                      w_r, x_r, own_r;

  // Walk and allocation state
  logic [1:0]       lv;
  logic [TBL_W-1:0] tabs [4];
  logic [TBL_W-1:0] newt;
  logic [TBL_W-1:0] made [3];
  logic [AW-1:0]    lnk  [3];
  logic [1:0]       cnt_n;
  logic [TBL_W-1:0] acnt;
  logic [IW-1:0]    zcnt;
  logic [IW-1:0]    scnt;
  logic             s_vld, s_last, s_done;
  logic [AW-1:0]    clr_cnt;

  // Result registers
  logic          res_ok, res_w, res_x;
  logic [FW-1:0] res_frame;
  logic          out_valid, out_ok, out_w, out_x;
  logic [FW-1:0] out_frame;

  // RAM and pool hookup
  logic [AW-1:0]       ram_addr;
  logic                ram_we;
  logic [EW-1:0]       ram_wdata, ram_rdata;
  rptm_pkg::pool_cmd_t pool_cmd;
  logic [TBL_W-1:0]    pool_widx;
  logic                pool_used;

  logic [IW-1:0]    idx_cur, idx_up;
  logic [1:0]       lv_up;
  logic             link_ok, addr_ok;
  logic [TBL_W-1:0] link_tbl;
  logic [1:0]       rb_i;
  logic             out_load;

  function automatic logic [IW-1:0] level_idx(input logic [rptm_pkg::VA_W-1:0] va,
                                               input logic [1:0] l);
    logic [IW-1:0] r;
    r = '0;
    case (l)
      2'd0:    r = va[47:39];
      2'd1:    r = va[38:30];
      2'd2:    r = va[29:21];
      default: r = va[20:12];
    endcase
    return r;
  endfunction

  rptm_ram #(.WIDTH(EW), .DEPTH(POOL_TABLES * rptm_pkg::TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  rptm_pool #(.POOL_TABLES(POOL_TABLES)) u_pool (
    .clk     (clk),
    .rst     (rst),
    .cmd     (pool_cmd),
    .wr_idx  (pool_widx),
    .rd_idx  (acnt),
    .rd_used (pool_used)
  );

  // Decode of the entry just read and the address check
  assign lv_up    = lv - 2'd1;
  assign idx_cur  = level_idx(va_r, lv);
  assign idx_up   = level_idx(va_r, lv_up);
  assign link_ok  = ram_rdata[0] && (ram_rdata[EW-1:3] < POOL_LIM);
  assign link_tbl = ram_rdata[TBL_W+2:3];
  assign addr_ok  = (va_r[11:0] == 12'd0) && (va_r >= window_base) &&
                    ({1'b0, va_r - window_base} < window_size);
  assign rb_i     = cnt_n - 2'd1;
  assign out_load = (state == S_FIN) && (!out_valid || rsp.ready);

  assign req.ready             = (state == S_IDLE);
  assign rsp.valid             = out_valid;
  assign rsp.ok                = out_ok;
  assign rsp.result_frame      = out_frame;
  assign rsp.result_writable   = out_w;
  assign rsp.result_executable = out_x;

  // Memory port and pool command selection
  always_comb begin
    ram_addr  = {tabs[lv], idx_cur};
    ram_we    = 1'b0;
    ram_wdata = '0;
    pool_cmd  = '0;
    pool_widx = acnt;
    unique case (state)
      S_CLR: begin
        ram_addr = clr_cnt;
        ram_we   = 1'b1;
      end
      S_EV: begin
        if (lv == 2'd3) begin
          if (op_r == rptm_pkg::OP_MAP) begin
            ram_we    = !ram_rdata[0];
            ram_wdata = {frame_r & FMASK, !x_r, w_r, 1'b1};
          end else if (ram_rdata[0] && op_r == rptm_pkg::OP_PROTECT) begin
            ram_we    = 1'b1;
            ram_wdata = {ram_rdata[EW-1:3], !x_r, w_r, 1'b1};
          end else if (ram_rdata[0] && op_r == rptm_pkg::OP_UNMAP) begin
            ram_we    = 1'b1;
          end
        end
      end
      S_AL: begin
        pool_cmd.set = !pool_used;
      end
      S_ZE: begin
        ram_addr = {newt, zcnt};
        ram_we   = 1'b1;
      end
      S_LK: begin
        ram_we    = 1'b1;
        ram_wdata = {(FW)'(newt), rptm_pkg::LINK_FLAGS};
      end
      S_RB: begin
        if (cnt_n != 2'd0) begin
          ram_addr     = lnk[rb_i];
          ram_we       = 1'b1;
          pool_cmd.clr = 1'b1;
          pool_widx    = made[rb_i];
        end
      end
      S_SC: begin
        ram_addr = {tabs[lv], scnt};
      end
      S_FR: begin
        ram_addr     = {tabs[lv_up], idx_up};
        ram_we       = 1'b1;
        pool_cmd.clr = 1'b1;
        pool_widx    = tabs[lv];
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= '0;
      window_size <= '0;
    end else if (cfg_write) begin
      if (cfg_index == rptm_pkg::CFG_WINDOW_BASE) begin
        window_base <= cfg_data[rptm_pkg::VA_W-1:0];
      end else begin
        window_size <= cfg_data;
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok    <= res_ok;
      out_frame <= res_frame;
      out_w     <= res_w;
      out_x     <= res_x;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (!addr_ok || (op_r == rptm_pkg::OP_MAP && !own_r)) begin
            state <= S_FIN;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          if (lv != 2'd3) begin
            if (link_ok) begin
              state <= S_RD;
            end else if (op_r == rptm_pkg::OP_MAP) begin
              state <= S_AL;
            end else begin
              state <= S_FIN;
            end
          end else if (ram_rdata[0] && op_r == rptm_pkg::OP_UNMAP) begin
            state <= S_SC;
          end else begin
            state <= S_FIN;
          end
        end
        S_AL: begin
          if (!pool_used) begin
            state <= S_ZE;
          end else if (acnt == LAST_TBL) begin
            state <= S_RB;
          end
        end
        S_ZE: begin
          if (zcnt == LAST_IDX) begin
            state <= S_LK;
          end
        end
        S_LK: begin
          state <= S_RD;
        end
        S_RB: begin
          if (cnt_n == 2'd0) begin
            state <= S_FIN;
          end
        end
        S_SC: begin
          if (s_vld && ram_rdata != '0) begin
            state <= S_FIN;
          end else if (s_vld && s_last) begin
            state <= S_FR;
          end
        end
        S_FR: begin
          if (lv == 2'd1) begin
            state <= S_FIN;
          end else begin
            state <= S_SC;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the sequencer
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_r    <= req.op;
        va_r    <= req.virtual_address;
        frame_r <= req.physical_frame;
        w_r     <= req.writable;
        x_r     <= req.executable;
        own_r   <= req.frame_allocated;
      end
      S_CHK: begin
        res_ok    <= 1'b0;
        res_frame <= '0;
        res_w     <= 1'b0;
        res_x     <= 1'b0;
        lv        <= 2'd0;
        tabs[0]   <= '0;
        cnt_n     <= 2'd0;
      end
      S_EV: begin
        if (lv != 2'd3) begin
          if (link_ok) begin
            tabs[lv + 2'd1] <= link_tbl;
            lv              <= lv + 2'd1;
          end else begin
            acnt <= TBL_W'(1);
          end
        end else if (op_r == rptm_pkg::OP_MAP) begin
          res_ok <= !ram_rdata[0];
        end else if (ram_rdata[0]) begin
          res_ok <= 1'b1;
          scnt   <= '0;
          s_vld  <= 1'b0;
          s_done <= 1'b0;
          if (op_r == rptm_pkg::OP_QUERY) begin
            res_frame <= ram_rdata[EW-1:3] & FMASK;
            res_w     <= ram_rdata[1];
            res_x     <= !ram_rdata[2];
          end
        end
      end
      S_AL: begin
        if (!pool_used) begin
          newt <= acnt;
          zcnt <= '0;
        end else begin
          acnt <= acnt + TBL_W'(1);
        end
      end
      S_ZE: begin
        zcnt <= zcnt + IW'(1);
      end
      S_LK: begin
        made[cnt_n]     <= newt;
        lnk[cnt_n]      <= {tabs[lv], idx_cur};
        cnt_n           <= cnt_n + 2'd1;
        tabs[lv + 2'd1] <= newt;
        lv              <= lv + 2'd1;
      end
      S_RB: begin
        if (cnt_n != 2'd0) begin
          cnt_n <= rb_i;
        end
      end
      S_SC: begin
        s_vld  <= !s_done;
        s_last <= (scnt == LAST_IDX);
        if (scnt == LAST_IDX) begin
          s_done <= 1'b1;
        end else begin
          scnt <= scnt + IW'(1);
        end
      end
      S_FR: begin
        lv     <= lv_up;
        scnt   <= '0;
        s_vld  <= 1'b0;
        s_done <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/rptm_ram.sv -----
// Generic single-port synchronous RAM, registered read (read-first).
// No dependencies.
module rptm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/rptm_pool.sv -----
// Table pool bitmap: one in-use bit per pool table, root set at reset.
// Depends on rptm_pkg for the command struct.
module rptm_pool #(
  parameter int POOL_TABLES = rptm_pkg::POOL_TABLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rptm_pkg::pool_cmd_t            cmd,
  input  logic [$clog2(POOL_TABLES)-1:0] wr_idx,
  input  logic [$clog2(POOL_TABLES)-1:0] rd_idx,
  output logic                           rd_used
);

  logic [POOL_TABLES-1:0] used;

  assign rd_used = used[rd_idx];

  // Set or clear one bit per cycle; only the root is in use after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= POOL_TABLES'(1);
    end else if (cmd.set) begin
      used[wr_idx] <= 1'b1;
    end else if (cmd.clr) begin
      used[wr_idx] <= 1'b0;
    end
  end

endmodule

// ----- bench/radix_page_table_manager_test.sv -----
// Testbench for the radix page table manager: directed and random requests,
// checked against a behavioral copy of the table state kept in this file.
// Depends on rptm_pkg, rptm_if and the radix_page_table_manager RTL.
`timescale 1ns / 100ps

module radix_page_table_manager_test;

  localparam int  POOL      = rptm_pkg::POOL_TABLES_DEF;
  localparam int  LIMIT     = 20_000_000;
  localparam int  SETTLE    = 60;

  typedef struct packed {
    logic                         ok;
    logic [rptm_pkg::FRAME_W-1:0] frame;
    logic                         wr;
    logic                         ex;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [rptm_pkg::CFG_W-1:0] cfg_data = '0;

  rptm_req_if req ();
  rptm_rsp_if rsp ();

  radix_page_table_manager DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the table state and the window
  logic [rptm_pkg::ENT_W-1:0]  shadow_mem [0:POOL*rptm_pkg::TABLE_ENTRIES-1];
  logic [POOL-1:0]             shadow_busy;
  logic [rptm_pkg::VA_W-1:0]   win_base;
  logic [rptm_pkg::SIZE_W-1:0] win_size;

  reply_t pending_replies [$];
  int  mismatches = 0;
  int  sent = 0;
  int  replies_seen = 0;
  int  query_hits = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.op = rptm_pkg::OP_QUERY;
    req.virtual_address = '0;
    req.physical_frame = '0;
    req.writable = 1'b0;
    req.executable = 1'b0;
    req.frame_allocated = 1'b0;
    rsp.ready = 1'b0;
  end

  function automatic int lvl_idx(input logic [rptm_pkg::VA_W-1:0] va, input int lv);
    return int'((va >> (39 - lv * 9)) & 48'd511);
  endfunction

  function automatic int ent_addr(input int t, input int i);
    return t * rptm_pkg::TABLE_ENTRIES + i;
  endfunction

  function automatic bit addr_in_window(input logic [rptm_pkg::VA_W-1:0] va);
    logic [rptm_pkg::SIZE_W-1:0] off;
    off = {1'b0, va} - {1'b0, win_base};
    return va[11:0] == 12'd0 && va >= win_base && off < win_size;
  endfunction

  // Follows present links; a link at or past the pool size counts as absent
  function automatic bit follow_path(input logic [rptm_pkg::VA_W-1:0] va,
                                     output int tabs[4], output int idx[4]);
    logic [rptm_pkg::ENT_W-1:0] e;
    tabs[0] = 0;
    for (int lv = 0; lv < 4; lv++) begin
      idx[lv] = lvl_idx(va, lv);
      e = shadow_mem[ent_addr(tabs[lv], idx[lv])];
      if (!e[0]) return 1'b0;
      if (lv < 3) begin
        if (e[rptm_pkg::ENT_W-1:3] >= POOL) return 1'b0;
        tabs[lv+1] = int'(e[rptm_pkg::ENT_W-1:3]);
      end
    end
    return 1'b1;
  endfunction

  function automatic int grab_table();
    for (int t = 1; t < POOL; t++)
      if (!shadow_busy[t]) begin
        shadow_busy[t] = 1'b1;
        for (int i = 0; i < rptm_pkg::TABLE_ENTRIES; i++) shadow_mem[ent_addr(t, i)] = '0;
        return t;
      end
    return -1;
  endfunction

  function automatic bit shadow_map(input logic [rptm_pkg::VA_W-1:0] va,
                                    input logic [rptm_pkg::FRAME_W-1:0] frame,
                                    input logic wr, input logic ex);
    int tab, n, t, a;
    int link_at [3];
    int took [3];
    logic [rptm_pkg::ENT_W-1:0] e;
    tab = 0;
    n = 0;
    for (int lv = 0; lv < 3; lv++) begin
      a = ent_addr(tab, lvl_idx(va, lv));
      e = shadow_mem[a];
      if (e[0] && e[rptm_pkg::ENT_W-1:3] < POOL) begin
        tab = int'(e[rptm_pkg::ENT_W-1:3]);
      end else begin
        t = grab_table();
        if (t < 0) begin
          // out of tables: give back what this request took
          while (n > 0) begin
            n--;
            shadow_mem[link_at[n]] = '0;
            shadow_busy[took[n]] = 1'b0;
          end
          return 1'b0;
        end
        link_at[n] = a;
        took[n] = t;
        n++;
        shadow_mem[a] = {40'(t), rptm_pkg::LINK_FLAGS};
        tab = t;
      end
    end
    a = ent_addr(tab, lvl_idx(va, 3));
    if (shadow_mem[a][0]) return 1'b0;
    shadow_mem[a] = {frame, !ex, wr, 1'b1};
    return 1'b1;
  endfunction

  function automatic void unmap_page(input int tabs[4], input int idx[4]);
    bit empty;
    shadow_mem[ent_addr(tabs[3], idx[3])] = '0;
    for (int lv = 3; lv > 0; lv--) begin
      empty = 1'b1;
      for (int i = 0; i < rptm_pkg::TABLE_ENTRIES; i++)
        if (shadow_mem[ent_addr(tabs[lv], i)] != '0) empty = 1'b0;
      if (!empty) return;
      shadow_mem[ent_addr(tabs[lv-1], idx[lv-1])] = '0;
      shadow_busy[tabs[lv]] = 1'b0;
    end
  endfunction

  // Expected response for one request, updating the shadow state
  function automatic reply_t predict_reply(input logic [1:0] op,
                                           input logic [rptm_pkg::VA_W-1:0] va,
                                           input logic [rptm_pkg::FRAME_W-1:0] frame,
                                           input logic wr, input logic ex,
                                           input logic owned);
    reply_t r;
    int tabs [4];
    int idx [4];
    int a;
    r = '0;
    if (!addr_in_window(va)) return r;
    if (op == rptm_pkg::OP_MAP) begin
      r.ok = owned && shadow_map(va, frame, wr, ex);
    end else if (follow_path(va, tabs, idx)) begin
      a = ent_addr(tabs[3], idx[3]);
      r.ok = 1'b1;
      case (op)
        rptm_pkg::OP_UNMAP: unmap_page(tabs, idx);
        rptm_pkg::OP_PROTECT: shadow_mem[a][2:0] = {!ex, wr, 1'b1};
        default: begin
          r.frame = shadow_mem[a][rptm_pkg::ENT_W-1:3];
          r.wr = shadow_mem[a][1];
          r.ex = !shadow_mem[a][2];
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("MISMATCH %s: got %0h expected %0h (response %0d)",
             what, got, want, replies_seen);
  endtask

  // Response checker
  always @(posedge clk) begin
    reply_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected response", 64'(rsp.ok), 64'd0);
      end else begin
        want = pending_replies.pop_front();
        if (rsp.ok !== want.ok) report_mismatch("ok", 64'(rsp.ok), 64'(want.ok));
        if (rsp.result_frame !== want.frame)
          report_mismatch("result_frame", 64'(rsp.result_frame), 64'(want.frame));
        if (rsp.result_writable !== want.wr)
          report_mismatch("result_writable", 64'(rsp.result_writable), 64'(want.wr));
        if (rsp.result_executable !== want.ex)
          report_mismatch("result_executable", 64'(rsp.result_executable),
                          64'(want.ex));
        if (want.ok && want.frame != 0) query_hits++;
      end
    end
  end

  // Response back-pressure
  always @(posedge clk)
    rsp.ready <= quiet || ($urandom_range(99) >= 11);

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout with %0d responses outstanding", pending_replies.size());
      $display("radix_page_table_manager test failed");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [rptm_pkg::VA_W-1:0] va,
                              input logic [rptm_pkg::FRAME_W-1:0] frame, input logic wr,
                              input logic ex, input logic owned);
    int gap;
    if (!quiet && $urandom_range(99) < 11) begin
      gap = $urandom_range(6, 1);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.virtual_address <= va;
    req.physical_frame <= frame;
    req.writable <= wr;
    req.executable <= ex;
    req.frame_allocated <= owned;
    do @(posedge clk); while (!req.ready);
    pending_replies.push_back(predict_reply(op, va, frame, wr, ex, owned));
    sent++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Only called with no request in flight
  task automatic write_reg(input logic idx, input logic [rptm_pkg::CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == rptm_pkg::CFG_WINDOW_BASE) win_base = data[rptm_pkg::VA_W-1:0];
    else win_size = data[rptm_pkg::SIZE_W-1:0];
  endtask

  task automatic set_window(input logic [rptm_pkg::VA_W-1:0] base,
                            input logic [rptm_pkg::SIZE_W-1:0] size);
    write_reg(rptm_pkg::CFG_WINDOW_BASE, rptm_pkg::CFG_W'(base));
    write_reg(rptm_pkg::CFG_WINDOW_SIZE, rptm_pkg::CFG_W'(size));
    @(posedge clk);
  endtask

  function automatic logic [rptm_pkg::VA_W-1:0] page_va(input int l0, input int l1,
                                                         input int l2, input int l3);
    return {9'(l0), 9'(l1), 9'(l2), 9'(l3), 12'd0};
  endfunction

  // Window is zero-sized out of reset: everything fails
  task automatic test_reset_window();
    send_request(rptm_pkg::OP_MAP, 48'h0, 40'h1, 1'b1, 1'b1, 1'b1);
    send_request(rptm_pkg::OP_QUERY, 48'h0, 40'h0, 1'b0, 1'b0, 1'b0);
    drain();
  endtask

  task automatic test_directed();
    logic [rptm_pkg::VA_W-1:0] top_va;
    top_va = 48'hFFFF_FFFF_F000;
    set_window(48'h0, 49'h1_0000_0000_0000);
    send_request(rptm_pkg::OP_QUERY, 48'h0, 40'h0, 1'b0, 1'b0, 1'b0);
    send_request(rptm_pkg::OP_MAP, 48'h0, 40'hFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1);
    send_request(rptm_pkg::OP_MAP, 48'h0, 40'h5, 1'b0, 1'b0, 1'b1);
    send_request(rptm_pkg::OP_MAP, 48'h1000, 40'h7, 1'b1, 1'b1, 1'b0);
    send_request(rptm_pkg::OP_QUERY, 48'h0, 40'h0, 1'b0, 1'b0, 1'b0);
    send_request(rptm_pkg::OP_PROTECT, 48'h0, 40'h0, 1'b0, 1'b0, 1'b1);
    send_request(rptm_pkg::OP_QUERY, 48'h0, 40'h0, 1'b0, 1'b0, 1'b0);
    send_request(rptm_pkg::OP_QUERY, 48'hFFFF_FFFF_FFFF, 40'h0, 1'b0, 1'b0, 1'b0);
    send_request(rptm_pkg::OP_MAP, 48'h0800, 40'h1, 1'b1, 1'b1, 1'b1);
    send_request(rptm_pkg::OP_MAP, top_va, 40'h0, 1'b0, 1'b0, 1'b1);
    send_request(rptm_pkg::OP_QUERY, top_va, 40'h0, 1'b1, 1'b1, 1'b1);
    send_request(rptm_pkg::OP_PROTECT, top_va, 40'h0, 1'b1, 1'b1, 1'b0);
    send_request(rptm_pkg::OP_QUERY, top_va, 40'h0, 1'b0, 1'b0, 1'b0);
    send_request(rptm_pkg::OP_UNMAP, top_va, 40'h0, 1'b0, 1'b0, 1'b0);
    send_request(rptm_pkg::OP_QUERY, top_va, 40'h0, 1'b0, 1'b0, 1'b0);
    send_request(rptm_pkg::OP_UNMAP, top_va, 40'h0, 1'b0, 1'b0, 1'b0);
    send_request(rptm_pkg::OP_PROTECT, top_va, 40'h0, 1'b1, 1'b0, 1'b0);
    send_request(rptm_pkg::OP_UNMAP, 48'h0, 40'h0, 1'b0, 1'b0, 1'b0);
    drain();
    // small window: below, inside, at the upper bound
    set_window(48'h1000, 49'h2000);
    send_request(rptm_pkg::OP_MAP, 48'h0, 40'h3, 1'b1, 1'b0, 1'b1);
    send_request(rptm_pkg::OP_MAP, 48'h2000, 40'h3, 1'b1, 1'b0, 1'b1);
    send_request(rptm_pkg::OP_MAP, 48'h3000, 40'h3, 1'b1, 1'b0, 1'b1);
    send_request(rptm_pkg::OP_QUERY, 48'h2000, 40'h0, 1'b0, 1'b0, 1'b0);
    send_request(rptm_pkg::OP_UNMAP, 48'h2000, 40'h0, 1'b0, 1'b0, 1'b0);
    drain();
    // highest base: no aligned address can pass
    set_window(48'hFFFF_FFFF_FFFF, 49'h1_FFFF_FFFF_FFFF);
    send_request(rptm_pkg::OP_MAP, top_va, 40'h3, 1'b1, 1'b0, 1'b1);
    drain();
  endtask

  // Fill the pool, then hit the limit with and without partial allocation
  task automatic test_pool_exhaustion();
    set_window(48'h0, 49'h1_0000_0000_0000);
    for (int i = 1; i <= 21; i++)
      send_request(rptm_pkg::OP_MAP, page_va(i, 0, 0, 0), 40'(i), 1'b1, 1'b1, 1'b1);
    send_request(rptm_pkg::OP_MAP, page_va(22, 0, 0, 0), 40'h1, 1'b1, 1'b1, 1'b1);
    send_request(rptm_pkg::OP_UNMAP, page_va(21, 0, 0, 0), 40'h0, 1'b0, 1'b0, 1'b0);
    send_request(rptm_pkg::OP_MAP, page_va(1, 5, 0, 0), 40'h55, 1'b0, 1'b1, 1'b1);
    send_request(rptm_pkg::OP_MAP, page_va(30, 0, 0, 0), 40'h66, 1'b1, 1'b1, 1'b1);
    send_request(rptm_pkg::OP_MAP, page_va(1, 6, 0, 0), 40'h77, 1'b1, 1'b1, 1'b1);
    send_request(rptm_pkg::OP_MAP, page_va(2, 0, 0, 9), 40'h88, 1'b1, 1'b0, 1'b1);
    send_request(rptm_pkg::OP_QUERY, page_va(2, 0, 0, 9), 40'h0, 1'b0, 1'b0, 1'b0);
    for (int i = 1; i <= 20; i++)
      send_request(rptm_pkg::OP_UNMAP, page_va(i, 0, 0, 0), 40'h0, 1'b0, 1'b0, 1'b0);
    send_request(rptm_pkg::OP_UNMAP, page_va(1, 5, 0, 0), 40'h0, 1'b0, 1'b0, 1'b0);
    send_request(rptm_pkg::OP_UNMAP, page_va(2, 0, 0, 9), 40'h0, 1'b0, 1'b0, 1'b0);
    drain();
  endtask

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 35) return rptm_pkg::OP_MAP;
    if (r < 55) return rptm_pkg::OP_UNMAP;
    if (r < 70) return rptm_pkg::OP_PROTECT;
    return rptm_pkg::OP_QUERY;
  endfunction

  // Pages drawn from a few hot paths so that maps, hits and frees all happen
  function automatic logic [rptm_pkg::VA_W-1:0] hot_va();
    int l0s [4] = '{0, 1, 300, 511};
    int l1s [4] = '{0, 7, 256, 511};
    if ($urandom_range(99) < 8) return 48'({$urandom(), $urandom()});
    return page_va(l0s[$urandom_range(3)], l1s[$urandom_range(3)],
                   $urandom_range(1) * 511, $urandom_range(7) * 73);
  endfunction

  task automatic random_batch(input int count, input bit in_window);
    logic [rptm_pkg::VA_W-1:0] va;
    int pages;
    pages = int'(win_size >> 12);
    for (int n = 0; n < count; n++) begin
      if (in_window)
        va = win_base + 48'(($urandom_range(pages + 1)) << 12) - 48'h1000;
      else
        va = hot_va();
      send_request(pick_op(), va, 40'({$urandom(), $urandom()}), 1'($urandom),
                   1'($urandom), $urandom_range(99) < 90);
    end
  endtask

  task automatic test_random_full_window();
    set_window(48'h0, 49'h1_0000_0000_0000);
    random_batch(250, 1'b0);
    // hold the sender until the block has answered everything
    req.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    quiet = 1'b1;
    random_batch(200, 1'b0);
    quiet = 1'b0;
    random_batch(150, 1'b0);
    drain();
  endtask

  task automatic test_random_window();
    logic [rptm_pkg::VA_W-1:0] base;
    base = {4'($urandom_range(15)), $urandom(), 12'd0};
    set_window(base, 49'(($urandom_range(24, 4)) << 12));
    random_batch(150, 1'b1);
    drain();
    set_window(48'hFFFF_FFFF_0000, 49'h1_0000);
    random_batch(100, 1'b1);
    drain();
  endtask

  initial begin
    for (int i = 0; i < POOL * rptm_pkg::TABLE_ENTRIES; i++) shadow_mem[i] = '0;
    shadow_busy = '0;
    shadow_busy[0] = 1'b1;
    win_base = '0;
    win_size = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_window();
    test_directed();
    test_pool_exhaustion();
    test_random_full_window();
    test_random_window();
    $display("Covered %0d requests (%0d query hits with a frame), %0d responses,",
             sent, query_hits, replies_seen);
    $display("with pool exhaustion, window edges and random back-pressure.");
    if (mismatches == 0 && pending_replies.size() == 0)
      $display("radix_page_table_manager test passed");
    else
      $display("radix_page_table_manager test failed");
    $finish;
  end

endmodule
